>>> hdl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine: command codes,
// segment phases and the engine state record.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  // command codes as carried in the mode field
  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_PUTACK = 3'd4,
    CMD_GETACK = 3'd5
  } cmd_t;

  // segment phases, idle when no command runs
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2,
    PH_THREE = 2'd3
  } phase_t;

  localparam int unsigned UNIT_W  = 8;
  localparam int unsigned WAIT_W  = 9;
  localparam int unsigned BITCNT_W = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [UNIT_W-1:0]   UNIT_RESET    = 8'd1;

  // register address decode
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_UNIT_TICKS = 1'b0;  // word index of unit_ticks

  typedef struct packed {
    phase_t              phase;
    cmd_t                cmd;
    logic [BITCNT_W-1:0] bit_count;
    logic [WAIT_W-1:0]   wait_count;
    logic [BYTE_W-1:0]   tx_shift;
    logic [BYTE_W-1:0]   rx_shift;
    logic                scl;
    logic                sda;
    logic                ack;
  } eng_state_t;

  localparam eng_state_t ENG_RESET = '{
    phase:      PH_IDLE,
    cmd:        CMD_START,
    bit_count:  '0,
    wait_count: '0,
    tx_shift:   '0,
    rx_shift:   '0,
    scl:        1'b1,
    sda:        1'b1,
    ack:        1'b1
  };

endpackage

>>> hdl/i2cmbe_cfg.sv
// ----------------------------------------------------------------------------
// i2cmbe_cfg
// APB register file holding the ticks-per-unit setting.
// ----------------------------------------------------------------------------
module i2cmbe_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2cmbe_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output logic [i2cmbe_pkg::UNIT_W-1:0]      unit_ticks
);
  import i2cmbe_pkg::*;

  logic wr_en;
  logic sel_unit;

  assign pready   = 1'b1;
  // word aligned decode, low address bits are ignored
  assign sel_unit = (paddr[CFG_ADDR_W-1] == REG_UNIT_TICKS);
  assign wr_en    = psel && penable && pwrite && pready && sel_unit;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_RESET;
    end else if (wr_en) begin
      unit_ticks <= pwdata[UNIT_W-1:0];
    end
  end

  assign prdata = sel_unit ? {{(32-UNIT_W){1'b0}}, unit_ticks} : '0;

endmodule

>>> hdl/i2cmbe_step.sv
// ----------------------------------------------------------------------------
// i2cmbe_step
// Next-state logic for one tick: command accept, wait countdown and the
// segment sequence of each command.
// ----------------------------------------------------------------------------
module i2cmbe_step (
  input  i2cmbe_pkg::eng_state_t          st,
  input  logic [i2cmbe_pkg::UNIT_W-1:0]   unit_ticks,
  input  logic                            cmd_valid,
  input  logic [2:0]                      mode,
  input  logic [i2cmbe_pkg::BYTE_W-1:0]   tx_byte,
  input  logic                            ack_level,
  input  logic                            sda_in,
  output i2cmbe_pkg::eng_state_t          nx,
  output logic                            done
);
  import i2cmbe_pkg::*;

  logic [WAIT_W-1:0] one_unit;
  logic [WAIT_W-1:0] two_units;

  // a zero setting acts as one
  assign one_unit  = (unit_ticks == '0) ? WAIT_W'(1) : {1'b0, unit_ticks};
  assign two_units = {one_unit[WAIT_W-2:0], 1'b0};

  always_comb begin
    nx   = st;
    done = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (cmd_valid && (mode <= 3'(CMD_GETACK))) begin
        nx.cmd       = cmd_t'(mode);
        nx.bit_count = '0;
        nx.phase     = PH_ONE;
        nx.scl       = 1'b0;
        case (cmd_t'(mode))
          CMD_START: begin
            nx.sda = 1'b1; nx.wait_count = WAIT_W'(1);
          end
          CMD_STOP: begin
            nx.sda = 1'b0; nx.wait_count = WAIT_W'(1);
          end
          CMD_WRITE: begin
            nx.tx_shift = tx_byte;
            nx.sda = tx_byte[BYTE_W-1]; nx.wait_count = two_units;
          end
          CMD_READ: begin
            nx.rx_shift = '0;
            nx.sda = 1'b1; nx.wait_count = WAIT_W'(1);
          end
          CMD_PUTACK: begin
            nx.sda = ack_level; nx.wait_count = two_units;
          end
          default: begin
            nx.sda = 1'b1; nx.wait_count = two_units;
          end
        endcase
      end
    end else begin
      if (st.wait_count != '0) nx.wait_count = st.wait_count - WAIT_W'(1);
      if (nx.wait_count == '0) begin
        case (st.cmd)
          CMD_START: begin
            if (st.phase == PH_ONE) begin
              nx.phase = PH_TWO; nx.scl = 1'b1; nx.sda = 1'b1; nx.wait_count = one_unit;
            end else if (st.phase == PH_TWO) begin
              nx.phase = PH_THREE; nx.scl = 1'b1; nx.sda = 1'b0; nx.wait_count = one_unit;
            end else begin
              nx.phase = PH_IDLE; nx.scl = 1'b0; nx.wait_count = '0; done = 1'b1;
            end
          end
          CMD_STOP: begin
            if (st.phase == PH_ONE) begin
              nx.phase = PH_TWO; nx.scl = 1'b1; nx.sda = 1'b0; nx.wait_count = one_unit;
            end else if (st.phase == PH_TWO) begin
              nx.phase = PH_THREE; nx.scl = 1'b1; nx.sda = 1'b1; nx.wait_count = two_units;
            end else begin
              nx.phase = PH_IDLE; nx.scl = 1'b1; nx.wait_count = '0; done = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (st.phase == PH_ONE) begin
              nx.phase      = PH_TWO;
              nx.scl        = 1'b1;
              nx.wait_count = one_unit;
              nx.tx_shift   = {st.tx_shift[BYTE_W-2:0], 1'b0};
              nx.bit_count  = st.bit_count + BITCNT_W'(1);
            end else if (st.bit_count < BITS_PER_BYTE) begin
              nx.phase      = PH_ONE;
              nx.scl        = 1'b0;
              nx.sda        = st.tx_shift[BYTE_W-1];
              nx.wait_count = two_units;
            end else begin
              nx.phase = PH_IDLE; nx.scl = 1'b0; nx.wait_count = '0; done = 1'b1;
            end
          end
          CMD_READ: begin
            if (st.phase == PH_ONE) begin
              nx.phase = PH_TWO; nx.scl = 1'b0; nx.sda = 1'b1; nx.wait_count = two_units;
            end else if (st.phase == PH_TWO) begin
              nx.phase      = PH_THREE;
              nx.scl        = 1'b1;
              nx.sda        = 1'b1;
              nx.wait_count = one_unit;
              nx.rx_shift   = {st.rx_shift[BYTE_W-2:0], sda_in};
              nx.bit_count  = st.bit_count + BITCNT_W'(1);
            end else if (st.bit_count < BITS_PER_BYTE) begin
              nx.phase = PH_TWO; nx.scl = 1'b0; nx.sda = 1'b1; nx.wait_count = two_units;
            end else begin
              nx.phase = PH_IDLE; nx.scl = 1'b0; nx.wait_count = '0; done = 1'b1;
            end
          end
          CMD_PUTACK: begin
            if (st.phase == PH_ONE) begin
              nx.phase = PH_TWO; nx.scl = 1'b1; nx.wait_count = one_unit;
            end else begin
              nx.phase = PH_IDLE; nx.scl = 1'b0; nx.wait_count = '0; done = 1'b1;
            end
          end
          CMD_GETACK: begin
            if (st.phase == PH_ONE) begin
              nx.phase = PH_TWO; nx.scl = 1'b1; nx.sda = 1'b1; nx.wait_count = one_unit;
              nx.ack   = sda_in;
            end else begin
              nx.phase = PH_IDLE; nx.scl = 1'b0; nx.wait_count = '0; done = 1'b1;
            end
          end
          default: begin
            nx.phase = PH_IDLE; nx.wait_count = '0; done = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

>>> hdl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Tick-driven I2C master line engine: every input transaction is one timing
// tick that may carry a command, every output transaction the line levels
// and status after that tick.
// ----------------------------------------------------------------------------
//
//  channel  direction  carries
//  -------  ---------  ------------------------------------------------------
//  s_*      in         one tick: command strobe, mode, tx byte, ack level, sda
//  m_*      out        one result per tick: scl, sda, busy, done, rx byte, ack
//  apb      in/out     unit_ticks register at byte address 0
//
//  one tick is taken per clock unless a stall on m_tready holds the result;
//  each tick passes through the input register, then the result register
//  the input register and the result register decouple the two sides; the
//  engine state advances only when a tick moves into the result register
//  a stall on m_tready backs up through one held tick, then drops s_tready
//  synchronous reset returns the lines to released and the engine to idle
//
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  // tick stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tx_byte[7:0], ack_level[8], sda_in[9], zero pad
  input  logic [3:0]  s_tuser,   // cmd_valid[0], mode[3:1]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl[0], sda[1], busy[2], done[3], rx_byte[11:4],
                                 // ack_seen[12], zero pad
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cmbe_pkg::*;

  // input register
  logic              in_valid;
  logic              in_cmd_valid;
  logic [2:0]        in_mode;
  logic [BYTE_W-1:0] in_tx_byte;
  logic              in_ack_level;
  logic              in_sda_in;

  // engine state and result register
  eng_state_t        st;
  eng_state_t        st_next;
  logic              done_next;
  logic              out_valid;
  logic [15:0]       out_data;

  logic [UNIT_W-1:0] unit_ticks;
  logic              s_take;
  logic              step_en;

  i2cmbe_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .unit_ticks (unit_ticks)
  );

  i2cmbe_step u_step (
    .st         (st),
    .unit_ticks (unit_ticks),
    .cmd_valid  (in_cmd_valid),
    .mode       (in_mode),
    .tx_byte    (in_tx_byte),
    .ack_level  (in_ack_level),
    .sda_in     (in_sda_in),
    .nx         (st_next),
    .done       (done_next)
  );

  // a held tick steps whenever the result slot is empty or being drained
  assign step_en  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step_en;
  assign s_take   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_take) begin
      in_valid <= 1'b1;
    end else if (step_en) begin
      in_valid <= 1'b0;
    end
  end

  // tick payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_take) begin
      in_cmd_valid <= s_tuser[0];
      in_mode      <= s_tuser[3:1];
      in_tx_byte   <= s_tdata[7:0];
      in_ack_level <= s_tdata[8];
      in_sda_in    <= s_tdata[9];
    end
  end

  // engine state follows each tick exactly once
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ENG_RESET;
    end else if (step_en) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= {3'b000, st_next.ack, st_next.rx_shift, done_next,
                   (st_next.phase != PH_IDLE), st_next.sda, st_next.scl};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
